// ----- src/ssod_pkg.sv -----
`default_nettype none

package ssod_pkg;

  // Field widths
  localparam int SAMPLE_W   = 32;
  localparam int WLEN_W     = 7;
  localparam int MINS_W     = 7;
  localparam int THR_W      = 17;
  localparam int HYS_W      = 17;
  localparam int OUT_CNT_W  = 6;
  localparam int EVT_W      = 32;
  localparam int SCNT_W     = 48;
  localparam int SIGN_W     = 2;

  // Config port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEN   = 3'd0,
    REG_MIN_SAMPLES  = 3'd1,
    REG_OSC_THR      = 3'd2,
    REG_CLEAR_HYS    = 3'd3
  } ssod_reg_e;

  // Register reset values
  localparam logic [WLEN_W-1:0] WLEN_RST = 7'd32;
  localparam logic [MINS_W-1:0] MINS_RST = 7'd2;
  localparam logic [THR_W-1:0]  THR_RST  = 17'd32768;
  localparam logic [HYS_W-1:0]  HYS_RST  = 17'd52429;

  // Smallest ring length and smallest evaluation count
  localparam int               MIN_RING = 4;
  localparam logic [MINS_W-1:0] MIN_OBS = 7'd2;

  // Slope sign codes
  localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'b00;
  localparam logic [SIGN_W-1:0] SIGN_POS  = 2'b01;
  localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'b11;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_CMP  = 2'd2,
    ST_DONE = 2'd3
  } ssod_state_e;

  // Control of the crossing counter
  typedef struct packed {
    logic clr;
    logic en;
  } ssod_scan_ctl_t;

endpackage

`default_nettype wire

// ----- src/ssod_cell.sv -----
`default_nettype none

// One slot of the sign chain: loads from its neighbor when the chain moves.
module ssod_cell (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           clr_i,
  input  wire logic                           en_i,
  input  wire logic [ssod_pkg::SIGN_W-1:0]    d_i,
  output logic      [ssod_pkg::SIGN_W-1:0]    q_o
);

  logic [ssod_pkg::SIGN_W-1:0] sign_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sign_q <= ssod_pkg::SIGN_ZERO;
    end else if (clr_i) begin
      sign_q <= ssod_pkg::SIGN_ZERO;
    end else if (en_i) begin
      sign_q <= d_i;
    end
  end

  assign q_o = sign_q;

endmodule

`default_nettype wire

// ----- src/ssod_scan.sv -----
`default_nettype none

// Counts sign changes in the stream leaving the chain, zero signs skipped.
module ssod_scan #(
  parameter int CNT_W = 7
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire ssod_pkg::ssod_scan_ctl_t       ctl_i,
  input  wire logic [ssod_pkg::SIGN_W-1:0]    sign_i,
  output logic      [CNT_W-1:0]               cnt_o
);

  logic [ssod_pkg::SIGN_W-1:0] prev_q, prev_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;

  always_comb begin
    prev_d = prev_q;
    cnt_d  = cnt_q;
    if (ctl_i.clr) begin
      prev_d = ssod_pkg::SIGN_ZERO;
      cnt_d  = '0;
    end else if (ctl_i.en) begin
      if (sign_i != ssod_pkg::SIGN_ZERO && prev_q != ssod_pkg::SIGN_ZERO &&
          sign_i != prev_q) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
      if (sign_i != ssod_pkg::SIGN_ZERO) begin
        prev_d = sign_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= ssod_pkg::SIGN_ZERO;
      cnt_q  <= '0;
    end else begin
      prev_q <= prev_d;
      cnt_q  <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

`default_nettype wire

// ----- src/ssod_decide.sv -----
`default_nettype none

// Threshold products and the rate compares (cross-multiplied, no divide).
module ssod_decide #(
  parameter int CNT_W = 7
) (
  input  wire logic                           clk_i,
  input  wire logic [ssod_pkg::THR_W-1:0]     thr_i,
  input  wire logic [ssod_pkg::HYS_W-1:0]     hys_i,
  input  wire logic [CNT_W-1:0]               pairs_i,
  input  wire logic [CNT_W-1:0]               crossings_i,
  output logic                                now_o,
  output logic                                below_o
);

  localparam int TH_W = ssod_pkg::THR_W + ssod_pkg::HYS_W;
  localparam int P1_W = ssod_pkg::THR_W + CNT_W;
  localparam int P2_W = TH_W + CNT_W;

  logic [TH_W-1:0] th_q;
  logic [P1_W-1:0] p1_q;
  logic [P2_W-1:0] p2_q;

  // Pair count stays put for the whole scan; config is to stay put too, which
  // the block does not enforce, so the products settle long before the compare.
  always_ff @(posedge clk_i) begin
    th_q <= TH_W'(thr_i) * TH_W'(hys_i);
    p1_q <= P1_W'(thr_i) * P1_W'(pairs_i);
    p2_q <= P2_W'(th_q) * P2_W'(pairs_i);
  end

  assign now_o   = P1_W'({crossings_i, 16'd0}) > p1_q;
  assign below_o = P2_W'({crossings_i, 32'd0}) < p2_q;

endmodule

`default_nettype wire

// ----- src/slope_sign_oscillation_detector_core.sv -----
`default_nettype none

// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+---------------------------------
// in       | sink      | in_valid_i / in_stall_o | sample_i
// out      | source    | out_valid_o / out_stall_i | rate_valid_o .. sample_total_o
// cfg      | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A seeding or unevaluated sample goes from idle straight to the hand-off
// state; an evaluated one first passes one full rotation of the sign chain past
// the crossing counter, then the compare state, then the hand-off state.
// Reset is asynchronous and clears the chain at once; a write to a known register
// index clears the chain, the history and both totals. The next sample is
// taken while a result still waits in the output register; a stalled output
// holds the block in its hand-off state only once a second result is ready.
module slope_sign_oscillation_detector_core #(
  parameter int MAX_WINDOW = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // sample input
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [ssod_pkg::SAMPLE_W-1:0] sample_i,
  // result output
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   rate_valid_o,
  output logic [ssod_pkg::OUT_CNT_W-1:0]         crossings_o,
  output logic [ssod_pkg::OUT_CNT_W-1:0]         pair_count_o,
  output logic                                   oscillating_o,
  output logic                                   osc_event_o,
  output logic                                   stable_event_o,
  output logic [ssod_pkg::EVT_W-1:0]             event_total_o,
  output logic [ssod_pkg::SCNT_W-1:0]            sample_total_o,
  // register writes
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [ssod_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [ssod_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int CMPW  = (CNT_W > ssod_pkg::WLEN_W) ? CNT_W : ssod_pkg::WLEN_W;
  localparam int OCW   = ssod_pkg::OUT_CNT_W;
  localparam int PADW  = (CNT_W > OCW) ? CNT_W : OCW;

  // Config registers
  logic [ssod_pkg::WLEN_W-1:0] win_len_q;
  logic [ssod_pkg::MINS_W-1:0] min_samp_q;
  logic [ssod_pkg::THR_W-1:0]  thr_q;
  logic [ssod_pkg::HYS_W-1:0]  hys_q;

  // Control state
  ssod_pkg::ssod_state_e       state_q, state_d;
  logic                        seeded_q;
  logic [CNT_W-1:0]            held_q;
  logic                        was_osc_q;
  logic [ssod_pkg::EVT_W-1:0]  evt_q;
  logic [ssod_pkg::SCNT_W-1:0] scnt_q;
  logic [CNT_W-1:0]            step_q;
  logic                        out_valid_q;

  // Payload
  logic signed [ssod_pkg::SAMPLE_W-1:0] last_q;
  logic [CNT_W-1:0]            pairs_q;
  logic [CNT_W-1:0]            skip_q;
  logic                        res_valid_q, res_osc_ev_q, res_stab_ev_q;
  logic                        o_rate_valid_q, o_osc_q, o_osc_ev_q, o_stab_ev_q;
  logic [OCW-1:0]              o_cross_q, o_pairs_q;
  logic [ssod_pkg::EVT_W-1:0]  o_evt_q;
  logic [ssod_pkg::SCNT_W-1:0] o_scnt_q;

  logic in_xfer, cfg_xfer, cfg_hit, out_free;
  logic push, scan_run, load_out, last_step, in_window;
  logic [ssod_pkg::SIGN_W-1:0] cur_sign;
  logic [CMPW-1:0]             wl_ext;
  logic [CNT_W-1:0]            ring_size, held_nx;
  logic [ssod_pkg::MINS_W-1:0] min_obs;
  logic                        eval_now;
  logic [CNT_W-1:0]            crossings;
  logic                        now, below;
  ssod_pkg::ssod_scan_ctl_t    scan_ctl;

  logic [ssod_pkg::SIGN_W-1:0] chain [MAX_WINDOW];

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    case (cfg_index_i)
      ssod_pkg::REG_WINDOW_LEN,
      ssod_pkg::REG_MIN_SAMPLES,
      ssod_pkg::REG_OSC_THR,
      ssod_pkg::REG_CLEAR_HYS: cfg_hit = 1'b1;
      default:                 cfg_hit = 1'b0;
    endcase
  end

  // Ring length, clamped to [4, MAX_WINDOW]
  assign wl_ext = CMPW'(win_len_q);
  always_comb begin
    if (wl_ext < CMPW'(ssod_pkg::MIN_RING)) begin
      ring_size = CNT_W'(ssod_pkg::MIN_RING);
    end else if (wl_ext > CMPW'(MAX_WINDOW)) begin
      ring_size = CNT_W'(MAX_WINDOW);
    end else begin
      ring_size = CNT_W'(wl_ext);
    end
  end

  assign held_nx  = (held_q < ring_size) ? held_q + CNT_W'(1) : held_q;
  assign min_obs  = (min_samp_q < ssod_pkg::MIN_OBS) ? ssod_pkg::MIN_OBS : min_samp_q;
  assign eval_now = CMPW'(held_nx) >= CMPW'(min_obs);

  // Slope sign of the new sample
  always_comb begin
    if (sample_i > last_q) begin
      cur_sign = ssod_pkg::SIGN_POS;
    end else if (sample_i < last_q) begin
      cur_sign = ssod_pkg::SIGN_NEG;
    end else begin
      cur_sign = ssod_pkg::SIGN_ZERO;
    end
  end

  assign last_step = (step_q == CNT_W'(MAX_WINDOW - 1));
  assign in_window = (step_q >= skip_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ssod_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = (seeded_q && eval_now) ? ssod_pkg::ST_SCAN : ssod_pkg::ST_DONE;
        end
      end
      ssod_pkg::ST_SCAN: begin
        if (last_step) begin
          state_d = ssod_pkg::ST_CMP;
        end
      end
      ssod_pkg::ST_CMP:  state_d = ssod_pkg::ST_DONE;
      ssod_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = ssod_pkg::ST_IDLE;
        end
      end
      default: state_d = ssod_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o = (state_q != ssod_pkg::ST_IDLE) || cfg_valid_i;
    scan_run   = (state_q == ssod_pkg::ST_SCAN);
    load_out   = (state_q == ssod_pkg::ST_DONE) && out_free;
  end

  assign push         = in_xfer && seeded_q;
  assign scan_ctl.clr = in_xfer;
  assign scan_ctl.en  = scan_run && in_window;

  // Sign chain: push shifts a new sign in, the scan rotates the chain once
  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    logic [ssod_pkg::SIGN_W-1:0] cell_d;
    if (k == 0) begin : g_head
      assign cell_d = push ? cur_sign : chain[MAX_WINDOW-1];
    end else begin : g_body
      assign cell_d = chain[k-1];
    end
    ssod_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .clr_i  (cfg_xfer && cfg_hit),
      .en_i   (push || scan_run),
      .d_i    (cell_d),
      .q_o    (chain[k])
    );
  end

  ssod_scan #(.CNT_W(CNT_W)) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (scan_ctl),
    .sign_i (chain[MAX_WINDOW-1]),
    .cnt_o  (crossings)
  );

  ssod_decide #(.CNT_W(CNT_W)) u_decide (
    .clk_i       (clk_i),
    .thr_i       (thr_q),
    .hys_i       (hys_q),
    .pairs_i     (pairs_q),
    .crossings_i (crossings),
    .now_o       (now),
    .below_o     (below)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q   <= ssod_pkg::WLEN_RST;
      min_samp_q  <= ssod_pkg::MINS_RST;
      thr_q       <= ssod_pkg::THR_RST;
      hys_q       <= ssod_pkg::HYS_RST;
      state_q     <= ssod_pkg::ST_IDLE;
      seeded_q    <= 1'b0;
      held_q      <= '0;
      was_osc_q   <= 1'b0;
      evt_q       <= '0;
      scnt_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_xfer) begin
        case (cfg_index_i)
          ssod_pkg::REG_WINDOW_LEN:  win_len_q  <= cfg_data_i[ssod_pkg::WLEN_W-1:0];
          ssod_pkg::REG_MIN_SAMPLES: min_samp_q <= cfg_data_i[ssod_pkg::MINS_W-1:0];
          ssod_pkg::REG_OSC_THR:     thr_q      <= cfg_data_i[ssod_pkg::THR_W-1:0];
          ssod_pkg::REG_CLEAR_HYS:   hys_q      <= cfg_data_i[ssod_pkg::HYS_W-1:0];
          default: ;
        endcase
        if (cfg_hit) begin
          seeded_q  <= 1'b0;
          held_q    <= '0;
          was_osc_q <= 1'b0;
          evt_q     <= '0;
          scnt_q    <= '0;
        end
      end
      if (in_xfer) begin
        scnt_q   <= scnt_q + ssod_pkg::SCNT_W'(1);
        seeded_q <= 1'b1;
        step_q   <= '0;
        if (seeded_q) begin
          held_q <= held_nx;
        end
      end
      if (scan_run) begin
        step_q <= step_q + CNT_W'(1);
      end
      if (state_q == ssod_pkg::ST_CMP) begin
        was_osc_q <= now;
        if (now && !was_osc_q) begin
          evt_q <= evt_q + ssod_pkg::EVT_W'(1);
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cfg_xfer && cfg_hit) begin
      last_q <= '0;
    end
    if (in_xfer) begin
      last_q        <= sample_i;
      res_osc_ev_q  <= 1'b0;
      res_stab_ev_q <= 1'b0;
      if (seeded_q && eval_now) begin
        res_valid_q <= 1'b1;
        pairs_q     <= held_nx - CNT_W'(1);
        skip_q      <= CNT_W'(MAX_WINDOW) - held_nx;
      end else begin
        res_valid_q <= 1'b0;
        pairs_q     <= '0;
        skip_q      <= '0;
      end
    end
    if (state_q == ssod_pkg::ST_CMP) begin
      res_osc_ev_q  <= now && !was_osc_q;
      res_stab_ev_q <= !now && was_osc_q && below;
    end
    if (load_out) begin
      o_rate_valid_q <= res_valid_q;
      o_cross_q      <= OCW'(PADW'(crossings));
      o_pairs_q      <= OCW'(PADW'(pairs_q));
      o_osc_q        <= was_osc_q;
      o_osc_ev_q     <= res_osc_ev_q;
      o_stab_ev_q    <= res_stab_ev_q;
      o_evt_q        <= evt_q;
      o_scnt_q       <= scnt_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign rate_valid_o   = o_rate_valid_q;
  assign crossings_o    = o_cross_q;
  assign pair_count_o   = o_pairs_q;
  assign oscillating_o  = o_osc_q;
  assign osc_event_o    = o_osc_ev_q;
  assign stable_event_o = o_stab_ev_q;
  assign event_total_o  = o_evt_q;
  assign sample_total_o = o_scnt_q;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input taken while a sample is still in work");

  a_osc_event_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && osc_event_o) |-> (oscillating_o && rate_valid_o))
    else $error("start event without oscillation flag");

  a_stable_event_clears_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stable_event_o) |-> (!oscillating_o && rate_valid_o))
    else $error("stabilize event while still oscillating");

  a_idle_window_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !rate_valid_o) |->
      (crossings_o == '0 && pair_count_o == '0 && !osc_event_o && !stable_event_o))
    else $error("unevaluated result carries window data");

endmodule

`default_nettype wire

// ----- sim/tb_slope_sign_oscillation_detector_core.sv -----
`default_nettype none

module tb_slope_sign_oscillation_detector_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ssod_pkg::*;

  localparam int RING_MAX    = 64;
  localparam int NUM_REGS    = int'(REG_CLEAR_HYS) + 1;
  localparam int QUIET_LIMIT = 4000;
  localparam int RUN_ITEMS   = 1800;

  // One result transfer, packed in port order
  typedef struct packed {
    logic                 rate_valid;
    logic [OUT_CNT_W-1:0] crossings;
    logic [OUT_CNT_W-1:0] pair_count;
    logic                 oscillating;
    logic                 osc_event;
    logic                 stable_event;
    logic [EVT_W-1:0]     event_total;
    logic [SCNT_W-1:0]    sample_total;
  } osc_result_t;

  // One register setting
  typedef struct {
    logic [WLEN_W-1:0] wl;
    logic [MINS_W-1:0] ms;
    logic [THR_W-1:0]  thr;
    logic [HYS_W-1:0]  hys;
  } osc_setting_t;

  typedef enum int {PAT_NOISE, PAT_SWING, PAT_RAMP, PAT_FLAT} pattern_e;

  // Slope sign rate tracker and queue of predicted results
  class slope_rate_scoreboard;
    logic [WLEN_W-1:0]          win_len;
    logic [MINS_W-1:0]          min_cnt;
    logic [THR_W-1:0]           thr;
    logic [HYS_W-1:0]           hys;
    logic signed [SAMPLE_W-1:0] prev_value;
    bit                         seeded;
    int                         slope_ring[RING_MAX];
    int unsigned                wr_pos;
    int unsigned                held;
    bit                         osc_flag;
    logic [EVT_W-1:0]           osc_events;
    logic [SCNT_W-1:0]          samples_seen;
    osc_result_t                predicted_q[$];
    int unsigned                errors;

    function new();
      errors  = 0;
      win_len = WLEN_RST;
      min_cnt = MINS_RST;
      thr     = THR_RST;
      hys     = HYS_RST;
      clear_state();
    endfunction

    function void clear_state();
      prev_value   = '0;
      seeded       = 1'b0;
      foreach (slope_ring[k]) slope_ring[k] = 0;
      wr_pos       = 0;
      held         = 0;
      osc_flag     = 1'b0;
      osc_events   = '0;
      samples_seen = '0;
    endfunction

    // A register write clears everything; unknown indexes are ignored
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WINDOW_LEN:  win_len = data[WLEN_W-1:0];
        REG_MIN_SAMPLES: min_cnt = data[MINS_W-1:0];
        REG_OSC_THR:     thr     = data[THR_W-1:0];
        REG_CLEAR_HYS:   hys     = data[HYS_W-1:0];
        default:         return;
      endcase
      clear_state();
    endfunction

    function int unsigned ring_len();
      int unsigned w;
      w = (win_len < MIN_RING) ? MIN_RING : win_len;
      if (w > RING_MAX) w = RING_MAX;
      return w;
    endfunction

    // Predict the result of one accepted sample
    function void note_sample(logic signed [SAMPLE_W-1:0] value);
      int unsigned size, n, start, min_need, c, pairs;
      int          slope, prv, cur;
      bit          now;
      osc_result_t r;
      size = ring_len();
      r    = '0;
      samples_seen = samples_seen + 1'b1;
      if (!seeded) begin
        prev_value = value;
        seeded     = 1'b1;
      end else begin
        slope      = (value > prev_value) ? 1 : ((value < prev_value) ? -1 : 0);
        prev_value = value;
        if (wr_pos >= size) wr_pos = 0;
        slope_ring[wr_pos] = slope;
        wr_pos = (wr_pos + 1) % size;
        if (held < size) held++;
        min_need = (min_cnt < MIN_OBS) ? 32'(MIN_OBS) : 32'(min_cnt);
        if (held >= min_need) begin
          n     = held;
          start = (wr_pos + 2 * size - n) % size;
          prv   = slope_ring[start];
          c     = 0;
          // count sign flips oldest to newest, zeros are skipped
          for (int i = 1; i < n; i++) begin
            cur = slope_ring[(start + i) % size];
            if (cur != 0 && prv != 0 && cur != prv) c++;
            if (cur != 0) prv = cur;
          end
          pairs = n - 1;
          now   = (64'(c) << 16) > (64'(thr) * 64'(pairs));
          if (now && !osc_flag) begin
            r.osc_event = 1'b1;
            osc_events  = osc_events + 1'b1;
          end else if (!now && osc_flag &&
                       ((64'(c) << 32) < (64'(thr) * 64'(hys) * 64'(pairs)))) begin
            r.stable_event = 1'b1;
          end
          osc_flag     = now;
          r.rate_valid = 1'b1;
          r.crossings  = c[OUT_CNT_W-1:0];
          r.pair_count = pairs[OUT_CNT_W-1:0];
        end
      end
      r.oscillating  = osc_flag;
      r.event_total  = osc_events;
      r.sample_total = samples_seen;
      predicted_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Compare one result transfer with the oldest prediction
    function void check_result(osc_result_t got);
      osc_result_t want;
      if (predicted_q.size() == 0) begin
        $error("result with no prediction pending");
        errors++;
        return;
      end
      want = predicted_q.pop_front();
      compare_field("rate_valid",   64'(want.rate_valid),   64'(got.rate_valid));
      compare_field("crossings",    64'(want.crossings),    64'(got.crossings));
      compare_field("pair_count",   64'(want.pair_count),   64'(got.pair_count));
      compare_field("oscillating",  64'(want.oscillating),  64'(got.oscillating));
      compare_field("osc_event",    64'(want.osc_event),    64'(got.osc_event));
      compare_field("stable_event", 64'(want.stable_event), 64'(got.stable_event));
      compare_field("event_total",  64'(want.event_total),  64'(got.event_total));
      compare_field("sample_total", 64'(want.sample_total), 64'(got.sample_total));
    endfunction

    function int unsigned pending();
      return predicted_q.size();
    endfunction
  endclass

  // DUT signals
  logic                       clk_i      = 1'b0;
  logic                       rst_ni     = 1'b0;
  logic                       in_valid   = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] in_sample  = '0;
  logic                       out_valid_o;
  logic                       out_stall  = 1'b0;
  logic                       rate_valid_o;
  logic [OUT_CNT_W-1:0]       crossings_o;
  logic [OUT_CNT_W-1:0]       pair_count_o;
  logic                       oscillating_o;
  logic                       osc_event_o;
  logic                       stable_event_o;
  logic [EVT_W-1:0]           event_total_o;
  logic [SCNT_W-1:0]          sample_total_o;
  logic                       cfg_valid  = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index  = '0;
  logic [CFG_DATA_W-1:0]      cfg_data   = '0;

  slope_rate_scoreboard sb = new();

  int unsigned                items_sent = 0;
  int unsigned                stall_left = 0;
  int unsigned                quiet      = 0;
  osc_result_t                seen_result;
  logic signed [SAMPLE_W-1:0] level      = '0;
  int                         dir        = 1;
  int                         swing_amp  = 1;

  slope_sign_oscillation_detector_core #(
    .MAX_WINDOW(RING_MAX)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .sample_i       (in_sample),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .rate_valid_o   (rate_valid_o),
    .crossings_o    (crossings_o),
    .pair_count_o   (pair_count_o),
    .oscillating_o  (oscillating_o),
    .osc_event_o    (osc_event_o),
    .stable_event_o (stable_event_o),
    .event_total_o  (event_total_o),
    .sample_total_o (sample_total_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result monitor and random output stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall === 1'b0) begin
      seen_result = {rate_valid_o, crossings_o, pair_count_o, oscillating_o,
                     osc_event_o, stable_event_o, event_total_o, sample_total_o};
      sb.check_result(seen_result);
    end
    if (stall_left != 0) begin
      stall_left--;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
          out_stall  <= 1'b0;
          stall_left = $urandom_range(1, 200);
        end
        19: begin
          out_stall  <= 1'b1;
          stall_left = $urandom_range(30, 150);
        end
        default: begin
          out_stall  <= 1'b1;
          stall_left = $urandom_range(0, 3);
        end
      endcase
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready_o === 1'b1)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("tb_slope_sign_oscillation_detector_core: errors");
      $finish;
    end
  end

  // Mostly short input gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  // Next value of the current signal pattern
  function automatic logic signed [SAMPLE_W-1:0] next_value(pattern_e pat);
    int unsigned r;
    r = $urandom_range(0, 15);
    case (pat)
      PAT_NOISE: begin
        if (r == 0) level = 32'sh7FFF_FFFF;
        else if (r == 1) level = 32'sh8000_0000;
        else if (r > 2) level = $urandom;
      end
      PAT_SWING: begin
        dir = -dir;
        if (r != 0) level = level + dir * swing_amp;
      end
      PAT_RAMP: begin
        if (r != 0) level = level + dir * int'($urandom_range(1, 64));
      end
      default: begin
        if (r == 0) level = level + int'($urandom_range(0, 6)) - 3;
      end
    endcase
    return level;
  endfunction

  // One sample transfer; valid stays high when no gap follows
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] value,
                             input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_sample(value);
    items_sent++;
  endtask

  // Hold off the sender until every predicted result has arrived
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // One register write transfer; valid is lowered by the caller
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Write the selected registers, upper data bits random for window length and minimum
  task automatic apply_setting(input osc_setting_t s, input logic [NUM_REGS-1:0] which);
    logic [CFG_DATA_W-1:0] d;
    for (int k = 0; k < NUM_REGS; k++) begin
      if (which[k]) begin
        d = CFG_DATA_W'($urandom);
        case (k)
          REG_WINDOW_LEN:  d[WLEN_W-1:0] = s.wl;
          REG_MIN_SAMPLES: d[MINS_W-1:0] = s.ms;
          REG_OSC_THR:     d = s.thr;
          default:         d = s.hys;
        endcase
        write_reg(CFG_IDX_W'(k), d);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic osc_setting_t random_setting();
    osc_setting_t s;
    int unsigned  eff;
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0: s.wl = 7'd0;
        1: s.wl = 7'd4;
        2: s.wl = 7'd64;
        default: s.wl = 7'd127;
      endcase
    end else begin
      s.wl = WLEN_W'($urandom_range(4, 64));
    end
    eff = (s.wl < MIN_RING) ? MIN_RING : ((s.wl > RING_MAX) ? RING_MAX : s.wl);
    if ($urandom_range(0, 9) == 0) s.ms = MINS_W'($urandom_range(eff + 1, 127));
    else s.ms = MINS_W'($urandom_range(0, eff));
    if ($urandom_range(0, 6) == 0) begin
      case ($urandom_range(0, 2))
        0: s.thr = 17'd0;
        1: s.thr = 17'd65536;
        default: s.thr = 17'd131071;
      endcase
    end else begin
      s.thr = THR_W'($urandom_range(8000, 60000));
    end
    if ($urandom_range(0, 6) == 0) begin
      case ($urandom_range(0, 2))
        0: s.hys = 17'd0;
        1: s.hys = 17'd65536;
        default: s.hys = 17'd131071;
      endcase
    end else begin
      s.hys = HYS_W'($urandom_range(30000, 65536));
    end
    return s;
  endfunction

  // Stream of pattern segments; optional mid-stream pause
  task automatic run_stream(input int unsigned count, input bit pause);
    pattern_e    pat;
    int unsigned seg_left, gap;
    bit          no_gaps;
    pat      = PAT_NOISE;
    seg_left = 0;
    no_gaps  = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      if (seg_left == 0) begin
        case ($urandom_range(0, 9))
          0, 1:    pat = PAT_NOISE;
          2, 3, 4, 5: begin
            pat       = PAT_SWING;
            swing_amp = $urandom_range(1, 5000);
          end
          6, 7, 8: begin
            pat = PAT_RAMP;
            dir = $urandom_range(0, 1) ? 1 : -1;
          end
          default: pat = PAT_FLAT;
        endcase
        seg_left = $urandom_range(3, 50);
      end
      seg_left--;
      if (pause && i == count / 2) drain();
      gap = no_gaps ? 0 : pick_gap();
      push_sample(next_value(pat), gap);
    end
    drain();
  endtask

  // Stimulus
  initial begin
    logic signed [SAMPLE_W-1:0] warmup [24];
    osc_setting_t               corners [7];
    warmup = '{32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
               32'sd10, -32'sd10, 32'sd10, -32'sd10, 32'sd10, -32'sd10,
               32'sd10, -32'sd10, 32'sd10, 32'sd20, 32'sd30, 32'sd40,
               32'sd40, 32'sd50, 32'sd60, 32'sd70, 32'sh7FFF_FFFF,
               32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    // window clamps, minimum above window, rate and hysteresis extremes
    corners = '{
      '{7'd0,   7'd0,   17'd0,      17'd0},
      '{7'd127, 7'd1,   17'd65536,  17'd65536},
      '{7'd64,  7'd64,  17'd131071, 17'd131071},
      '{7'd4,   7'd65,  17'd32768,  17'd52429},
      '{7'd127, 7'd127, 17'd1,      17'd0},
      '{7'd5,   7'd2,   17'd1,      17'd131071},
      '{7'd33,  7'd7,   17'd20000,  17'd30000}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, seed, extremes, zero slope, swing then ramp
    foreach (warmup[k]) push_sample(warmup[k], (k % 3 == 1) ? pick_gap() : 0);
    drain();

    foreach (corners[k]) begin
      apply_setting(corners[k], '1);
      run_stream(90, k == 0);
    end

    // write to an index past the register list leaves state untouched
    write_reg(CFG_IDX_W'(NUM_REGS + $urandom_range(0, 7 - NUM_REGS)), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    run_stream(40, 1'b0);

    while (items_sent < RUN_ITEMS) begin
      if ($urandom_range(0, 4) != 0) begin
        apply_setting(random_setting(), NUM_REGS'($urandom_range(1, 15)));
      end
      run_stream($urandom_range(40, 160), $urandom_range(0, 2) == 0);
    end

    repeat (RING_MAX + 16) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_slope_sign_oscillation_detector_core: clean");
    end else begin
      $display("tb_slope_sign_oscillation_detector_core: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
